@@ rtl/pomd_pkg.sv @@
// pomd_pkg: shared types, constants and register indexes for the
// perturb-and-observe duty tracker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pomd_pkg;

  // adc resolution actually used from each 12-bit code field
  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned CODE_W   = 12;
  localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((1 << ADC_BITS) - 1);

  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned POWER_W = 24;
  localparam int unsigned HINT_W  = 8;

  // wide enough for duty plus or minus one step, with sign
  localparam int unsigned SUM_W = DUTY_W + 2;

  // reset values
  localparam logic [DUTY_W-1:0]  DUTY_LO_RST      = 16'd200;
  localparam logic [DUTY_W-1:0]  DUTY_HI_RST      = 16'd3600;
  localparam logic [DUTY_W-1:0]  PERTURB_STEP_RST = 16'd40;
  localparam logic [POWER_W-1:0] DEADBAND_RST     = 24'd10228;
  localparam logic [DUTY_W-1:0]  TIMER_TOP_RST    = 16'd3999;
  localparam logic [DUTY_W-1:0]  DUTY_REG_RST     = 16'd200;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_LO      = 3'd0,
    CFG_DUTY_HI      = 3'd1,
    CFG_PERTURB_STEP = 3'd2,
    CFG_DEADBAND     = 3'd3,
    CFG_TIMER_TOP    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_START  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_lo;
    logic [DUTY_W-1:0]  duty_hi;
    logic [DUTY_W-1:0]  perturb_step;
    logic [POWER_W-1:0] deadband;
    logic [DUTY_W-1:0]  timer_top;
  } cfg_t;

  // one classified item: start carries hint fraction times timer_top,
  // sample carries raw power
  typedef struct packed {
    mode_e              mode;
    logic [POWER_W-1:0] prod;
  } qentry_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [POWER_W-1:0] power;
    logic               going_down;
    logic               reversed;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/perturb_observe_mppt_duty.sv @@
// perturb_observe_mppt_duty: top level of the perturb-and-observe duty tracker
// depends on pomd_pkg, pomd_cfg, pomd_front, pomd_queue, pomd_back
//
// usage
//   input stream: one beat is one item; tuser selects start (0) or sample (1).
//   a start beat seeds the duty from the signed hint scaled by timer_top,
//   forces direction up and forgets the previous power. a sample beat
//   multiplies voltage and current codes, reverses direction when power
//   dropped by more than the deadband, then steps and clamps the duty.
//   output stream: exactly one result beat per input beat, in order.
//   config port: write-only; cfg_we_i with cfg_idx_i/cfg_wdata_i writes one
//   register (duty_lo, duty_hi, perturb_step, deadband, timer_top). write
//   only while no item is in flight; unknown indexes are ignored.
// timing
//   path: an input beat is written into the queue, then popped into the
//   output register, where its result beat is valid until it is taken.
//   throughput: one item per cycle while m_axis_tready is high, set by the
//   state update in the back end (compare, step and clamp are combinational).
//   a two-entry queue sits between the multiplier front and the state back,
//   so input is still taken while a result waits on m_axis_tready; once the
//   queue and output register are full, s_axis_tready drops.
// reset
//   rst_ni low clears the queue and output valid, loads register defaults,
//   duty 200, direction up and no previous power.
`timescale 1ns / 1ps
`default_nettype none

module perturb_observe_mppt_duty
  import pomd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [31:0]           s_axis_tdata,  // hint[7:0], volt_code[19:8], curr_code[31:20]
  input  wire logic                  s_axis_tuser,  // mode[0]
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [47:0]                m_axis_tdata,  // duty[15:0], power_raw[39:16],
                                                    // going_down[40], reversed[41], zero[47:42]
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  qentry_t f_entry;
  qentry_t q_head;
  logic    f_push;
  logic    q_full;
  logic    q_valid;
  logic    b_pop;
  result_t res;

  pomd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // front: classify and multiply as the beat is taken
  pomd_front u_front (
    .valid_i     (s_axis_tvalid),
    .mode_i      (s_axis_tuser),
    .hint_i      (s_axis_tdata[7:0]),
    .volt_i      (s_axis_tdata[19:8]),
    .curr_i      (s_axis_tdata[31:20]),
    .timer_top_i (cfg.timer_top),
    .q_full_i    (q_full),
    .ready_o     (s_axis_tready),
    .push_o      (f_push),
    .entry_o     (f_entry)
  );

  // products are registered here before the back end uses them
  pomd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_entry),
    .pop_i   (b_pop),
    .rdata_o (q_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // back: tracker state and output register
  pomd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .entry_i       (q_head),
    .entry_valid_i (q_valid),
    .pop_o         (b_pop),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_o         (res)
  );

  assign m_axis_tdata = {6'b0, res.reversed, res.going_down, res.power, res.duty};

endmodule

`default_nettype wire

@@ rtl/pomd_cfg.sv @@
// pomd_cfg: configuration register file with write-only port
// depends on pomd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pomd_cfg
  import pomd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [CFG_IDX_W-1:0]  idx_i,
  input  wire logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_DUTY_LO:      cfg_d.duty_lo      = wdata_i[DUTY_W-1:0];
        CFG_DUTY_HI:      cfg_d.duty_hi      = wdata_i[DUTY_W-1:0];
        CFG_PERTURB_STEP: cfg_d.perturb_step = wdata_i[DUTY_W-1:0];
        CFG_DEADBAND:     cfg_d.deadband     = wdata_i[POWER_W-1:0];
        CFG_TIMER_TOP:    cfg_d.timer_top    = wdata_i[DUTY_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_lo      <= DUTY_LO_RST;
      cfg_q.duty_hi      <= DUTY_HI_RST;
      cfg_q.perturb_step <= PERTURB_STEP_RST;
      cfg_q.deadband     <= DEADBAND_RST;
      cfg_q.timer_top    <= TIMER_TOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/pomd_front.sv @@
// pomd_front: accepts input beats, classifies start vs sample and forms
// the single product each item needs; depends on pomd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pomd_front
  import pomd_pkg::*;
(
  input  wire logic              valid_i,
  input  wire logic              mode_i,
  input  wire logic [HINT_W-1:0] hint_i,
  input  wire logic [CODE_W-1:0] volt_i,
  input  wire logic [CODE_W-1:0] curr_i,
  input  wire logic [DUTY_W-1:0] timer_top_i,
  input  wire logic              q_full_i,
  output logic                   ready_o,
  output logic                   push_o,
  output qentry_t                entry_o
);

  logic [HINT_W-1:0]  frac;
  logic [CODE_W-1:0]  v_m;
  logic [CODE_W-1:0]  c_m;
  logic [POWER_W-1:0] start_prod;
  logic [POWER_W-1:0] samp_prod;

  // hint + 128 is the offset-binary form of the signed hint
  assign frac = hint_i ^ {1'b1, {(HINT_W-1){1'b0}}};
  assign v_m  = volt_i & ADC_MASK;
  assign c_m  = curr_i & ADC_MASK;

  assign start_prod = POWER_W'(frac) * POWER_W'(timer_top_i);
  assign samp_prod  = POWER_W'(v_m) * POWER_W'(c_m);

  always_comb begin
    entry_o.mode = mode_e'(mode_i);
    unique case (mode_e'(mode_i))
      MODE_START:  entry_o.prod = start_prod;
      MODE_SAMPLE: entry_o.prod = samp_prod;
      default:     entry_o.prod = samp_prod;
    endcase
  end

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && ready_o;

endmodule

`default_nettype wire

@@ rtl/pomd_queue.sv @@
// pomd_queue: two-entry queue decoupling the front from the back
// depends on pomd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pomd_queue
  import pomd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  qentry_t   wdata_i,
  input  wire logic pop_i,
  output qentry_t   rdata_o,
  output logic      valid_o,
  output logic      full_o
);

  qentry_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

@@ rtl/pomd_back.sv @@
// pomd_back: tracker state, direction decision, step and clamp, and the
// output register; depends on pomd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pomd_back
  import pomd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  qentry_t   entry_i,
  input  wire logic entry_valid_i,
  output logic      pop_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output result_t   out_o
);

  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic               dir_q, dir_d;
  logic [POWER_W-1:0] last_pwr_q, last_pwr_d;
  logic               last_vld_q, last_vld_d;
  logic               out_vld_q, out_vld_d;
  result_t            res_q, res_d;

  logic [POWER_W-1:0] drop;
  logic               flip;
  logic               dir_n;
  logic signed [SUM_W-1:0] raw;
  logic signed [SUM_W-1:0] lo_lim;
  logic signed [SUM_W-1:0] hi_lim;
  logic signed [SUM_W-1:0] clamped;

  assign pop_o = entry_valid_i && (!out_vld_q || out_ready_i);

  assign drop = last_pwr_q - entry_i.prod;
  assign flip = last_vld_q && (last_pwr_q > entry_i.prod) && (drop > cfg_i.deadband);
  assign dir_n = dir_q ^ flip;

  assign lo_lim = SUM_W'({2'b00, cfg_i.duty_lo});
  assign hi_lim = SUM_W'({2'b00, cfg_i.duty_hi});

  always_comb begin
    unique case (entry_i.mode)
      MODE_START:  raw = SUM_W'({2'b00, entry_i.prod[POWER_W-1 -: DUTY_W]});
      MODE_SAMPLE: raw = dir_n ? SUM_W'({2'b00, duty_q}) - SUM_W'({2'b00, cfg_i.perturb_step})
                               : SUM_W'({2'b00, duty_q}) + SUM_W'({2'b00, cfg_i.perturb_step});
      default:     raw = SUM_W'({2'b00, duty_q});
    endcase
  end

  // lower limit first, then upper: crossed limits end at the upper limit
  always_comb begin
    clamped = raw;
    if (clamped < lo_lim) begin
      clamped = lo_lim;
    end
    if (clamped > hi_lim) begin
      clamped = hi_lim;
    end
  end

  always_comb begin
    duty_d     = duty_q;
    dir_d      = dir_q;
    last_pwr_d = last_pwr_q;
    last_vld_d = last_vld_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    if (pop_o) begin
      duty_d    = clamped[DUTY_W-1:0];
      out_vld_d = 1'b1;
      unique case (entry_i.mode)
        MODE_START: begin
          dir_d      = 1'b0;
          last_pwr_d = '0;
          last_vld_d = 1'b0;
          res_d.power    = '0;
          res_d.reversed = 1'b0;
        end
        MODE_SAMPLE: begin
          dir_d      = dir_n;
          last_pwr_d = entry_i.prod;
          last_vld_d = 1'b1;
          res_d.power    = entry_i.prod;
          res_d.reversed = flip;
        end
        default: begin
          dir_d = dir_q;
        end
      endcase
      res_d.duty       = clamped[DUTY_W-1:0];
      res_d.going_down = dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q     <= DUTY_REG_RST;
      dir_q      <= 1'b0;
      last_pwr_q <= '0;
      last_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      duty_q     <= duty_d;
      dir_q      <= dir_d;
      last_pwr_q <= last_pwr_d;
      last_vld_q <= last_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/pomd_checker.sv @@
// pomd_checker: port-level assertions for perturb_observe_mppt_duty and its bind
// depends on pomd_pkg and the top level
`timescale 1ns / 1ps
`default_nettype none

module pomd_checker
  import pomd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] inflight_q, inflight_d;
  logic       last_gd_q;
  logic       seen_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    priority if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      last_gd_q  <= 1'b0;
      seen_q     <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      if (out_beat) begin
        last_gd_q <= m_axis_tdata[40];
        seen_q    <= 1'b1;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (inflight_q != 3'd0) || in_beat)
    else $error("result beat with nothing in flight");

  // queue plus output register bound what can be outstanding
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("too many items in flight");

  // a reversal really changes the direction shown
  a_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_q && m_axis_tdata[41] |-> m_axis_tdata[40] != last_gd_q)
    else $error("reversed flag without direction change");

endmodule

bind perturb_observe_mppt_duty pomd_checker u_pomd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
